// ===== rtl/core/ald_pkg.sv =====
// Shared types, constants and handshake structs for the adjacent line dedup block.
package ald_pkg;

  localparam int unsigned LINE_MAX_DEF = 32;
  localparam int unsigned COUNT_W      = 24;
  localparam int unsigned CW_W         = 6;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [7:0]         NEWLINE   = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ALL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_ONLY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_WIDTH = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               has_byte;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_of_line;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CLOSE,
    ST_TAIL,
    ST_EM_RD,
    ST_EM_LD,
    ST_AFTER
  } ald_state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap_byte;    // store incoming byte, look up run byte at same position
    logic open_only;   // byte dropped past line limit, line stays open
    logic cmp;         // fold lookup result into prefix mismatch
    logic keep;        // line matches run: bump count
    logic take;        // incoming line becomes the run
    logic clr_inc;     // clear incoming line state
    logic clr_await;   // first line seen
    logic flush_rst;   // back to post-reset run state
    logic em_start;    // emission index to zero
    logic em_load;     // push one item into the output register
    logic em_active;   // read address follows the emission index
  } ald_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_flush;
    logic in_zero;
    logic in_nl;
    logic inc_full;
    logic line_open;
    logic awaiting;
    logic mismatch;    // prefix mismatch including the short-line rule
    logic emit_ok;
    logic em_last;
    logic out_free;
  } ald_stat_t;

endpackage

// ===== rtl/core/adjacent_line_dedup.sv =====
// Top level: adjacent duplicate line filter with configuration port.
//
// Input channel (in_valid, in_stall, in_data): one text byte or an end-of-input
// command per item. Zero bytes are dropped, a newline closes a line, bytes past
// LINE_MAX are dropped while the line stays open.
// Result channel (out_valid, out_stall, out_data): each emitted run comes out as
// one item per byte of its stored line with the run's repeat count; an empty
// line is one item with has_byte clear. last_of_line marks the final item.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while the block is idle.
// Sequence: a stored data byte is written with a registered lookup of the run
// byte in the line memory, then compared in ST_CMP; a zero byte or a byte past
// LINE_MAX is taken in ST_IDLE alone. A newline passes ST_CLOSE when no run is
// emitted, otherwise ST_EM_RD and ST_EM_LD per emitted byte, then ST_AFTER, an
// order set by the single read port of the line memory; in_stall stays high
// until ST_IDLE. A flush adds one more emission of the last run.
// The output register holds a result while out_stall is high; emission waits,
// but a stalled output never blocks an accepted byte that emits nothing.
// Reset (synchronous, rst_n low) clears the control and config registers and the
// run state; line memories and data registers need no clearing.
module adjacent_line_dedup import ald_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW_W-1:0]      cfg_data
);

  ald_cmd_t  cmd;
  ald_stat_t stat;

  assign cfg_ready = 1'b1;

  ald_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ald_datapath #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/ald_datapath.sv =====
// Datapath: line stores, lengths, run count, compare logic and output register.
module ald_datapath import ald_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW_W-1:0]      cfg_data,
  input  ald_cmd_t             cmd,
  output ald_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int unsigned AW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
  localparam int unsigned DEPTH = 2 << AW;
  localparam logic [LEN_W-1:0] LMAX_L = LEN_W'(LINE_MAX);
  localparam logic [CW_W-1:0]  LMAX_C = CW_W'(LINE_MAX);

  // Two banks: sel_r picks the run line, the other bank takes the incoming line
  logic [7:0]         mem [DEPTH];
  logic [7:0]         rdata_r;
  logic [AW:0]        rd_addr;
  logic               sel_r;
  logic [LEN_W-1:0]   run_len_r;
  logic [LEN_W-1:0]   inc_len_r;
  logic               mismatch_r;
  logic [COUNT_W-1:0] run_count_r;
  logic               await_r;
  logic               open_r;
  logic [LEN_W-1:0]   p_r;
  logic [7:0]         b_r;
  logic [AW-1:0]      idx_r;
  logic               show_r;
  logic               uniq_r;
  logic [CW_W-1:0]    cw_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic [LEN_W-1:0]   lim;
  logic               out_free;

  always_comb begin
    if (cw_r == '0 || cw_r > LMAX_C) begin
      lim = LMAX_L;
    end else begin
      lim = cw_r[LEN_W-1:0];
    end
  end

  assign rd_addr  = cmd.em_active ? {sel_r, idx_r} : {sel_r, inc_len_r[AW-1:0]};
  assign out_free = !out_valid_r || !out_stall;

  assign stat.in_flush  = (in_data.command == CMD_FLUSH);
  assign stat.in_zero   = (in_data.data_byte == 8'd0);
  assign stat.in_nl     = (in_data.data_byte == NEWLINE);
  assign stat.inc_full  = (inc_len_r >= LMAX_L);
  assign stat.line_open = open_r;
  assign stat.awaiting  = await_r;
  assign stat.mismatch  = mismatch_r || (inc_len_r < lim && inc_len_r < run_len_r);
  assign stat.emit_ok   = show_r || !uniq_r || (run_count_r == COUNT_W'(1));
  assign stat.em_last   = (run_len_r == '0) || (LEN_W'(idx_r) + LEN_W'(1) == run_len_r);
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.cap_byte) begin
      mem[{~sel_r, inc_len_r[AW-1:0]}] <= in_data.data_byte;
      p_r <= inc_len_r;
      b_r <= in_data.data_byte;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_r      <= 1'b0;
      uniq_r      <= 1'b0;
      cw_r        <= '0;
      sel_r       <= 1'b0;
      run_len_r   <= '0;
      inc_len_r   <= '0;
      mismatch_r  <= 1'b0;
      run_count_r <= '0;
      await_r     <= 1'b1;
      open_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT_ALL:     show_r <= cfg_data[0];
          CFG_UNIQUE_ONLY:   uniq_r <= cfg_data[0];
          CFG_COMPARE_WIDTH: cw_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cap_byte) begin
        inc_len_r <= inc_len_r + LEN_W'(1);
        open_r    <= 1'b1;
      end
      if (cmd.open_only) begin
        open_r <= 1'b1;
      end
      if (cmd.cmp && !await_r && p_r < lim && (p_r >= run_len_r || rdata_r != b_r)) begin
        mismatch_r <= 1'b1;
      end
      if (cmd.keep && run_count_r != COUNT_MAX) begin
        run_count_r <= run_count_r + COUNT_W'(1);
      end
      if (cmd.take) begin
        sel_r       <= ~sel_r;
        run_len_r   <= inc_len_r;
        run_count_r <= COUNT_W'(1);
      end
      if (cmd.clr_inc) begin
        inc_len_r  <= '0;
        mismatch_r <= 1'b0;
        open_r     <= 1'b0;
      end
      if (cmd.clr_await) begin
        await_r <= 1'b0;
      end
      if (cmd.flush_rst) begin
        await_r     <= 1'b1;
        run_count_r <= '0;
        run_len_r   <= '0;
        inc_len_r   <= '0;
        mismatch_r  <= 1'b0;
        open_r      <= 1'b0;
      end
      if (cmd.em_start) begin
        idx_r <= '0;
      end else if (cmd.em_load) begin
        idx_r <= idx_r + AW'(1);
      end
      if (cmd.em_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      out_data_r.out_byte     <= (run_len_r == '0) ? 8'd0 : rdata_r;
      out_data_r.has_byte     <= (run_len_r != '0);
      out_data_r.repeat_count <= run_count_r;
      out_data_r.last_of_line <= stat.em_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // a held result must never be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_load |-> out_free)
    else $error("output register overwritten while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.has_byte) |-> out_data_r.last_of_line)
    else $error("empty line item not marked last");

  a_await_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (run_count_r == '0 && run_len_r == '0))
    else $error("run state present while awaiting first line");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_byte |=> (inc_len_r <= LMAX_L && open_r))
    else $error("incoming line length beyond limit");
`endif

endmodule

// ===== rtl/core/ald_ctrl.sv =====
// Controller: sequences byte compare, line close, run emission and flush.
module ald_ctrl import ald_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ald_stat_t stat,
  output ald_cmd_t  cmd
);

  ald_state_t state_r, state_nxt;
  logic       flushing_r, flushing_nxt;
  logic       tail_r, tail_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      flushing_r <= 1'b0;
      tail_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      flushing_r <= flushing_nxt;
      tail_r     <= tail_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    flushing_nxt = flushing_r;
    tail_nxt     = tail_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (stat.in_flush) begin
            flushing_nxt = 1'b1;
            if (stat.line_open) begin
              state_nxt = ST_CLOSE;
            end else if (!stat.awaiting) begin
              state_nxt = ST_TAIL;
            end else begin
              flushing_nxt = 1'b0;
            end
          end else if (stat.in_nl) begin
            flushing_nxt = 1'b0;
            state_nxt    = ST_CLOSE;
          end else if (!stat.in_zero && !stat.inc_full) begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: state_nxt = ST_IDLE;
      ST_CLOSE: begin
        if (!stat.awaiting && stat.mismatch && stat.emit_ok) begin
          tail_nxt  = 1'b0;
          state_nxt = ST_EM_RD;
        end else begin
          state_nxt = flushing_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (stat.emit_ok) begin
          tail_nxt  = 1'b1;
          state_nxt = ST_EM_RD;
        end else begin
          flushing_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EM_RD: state_nxt = ST_EM_LD;
      ST_EM_LD: begin
        if (stat.out_free) begin
          state_nxt = stat.em_last ? ST_AFTER : ST_EM_RD;
        end
      end
      ST_AFTER: begin
        if (tail_r) begin
          tail_nxt     = 1'b0;
          flushing_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = flushing_r ? ST_TAIL : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (stat.in_flush) begin
            if (!stat.line_open && stat.awaiting) begin
              cmd.flush_rst = 1'b1;
            end
          end else if (!stat.in_zero && !stat.in_nl) begin
            cmd.cap_byte  = !stat.inc_full;
            cmd.open_only = stat.inc_full;
          end
        end
      end
      ST_CMP: cmd.cmp = 1'b1;
      ST_CLOSE: begin
        if (stat.awaiting) begin
          cmd.take      = 1'b1;
          cmd.clr_await = 1'b1;
          cmd.clr_inc   = 1'b1;
        end else if (!stat.mismatch) begin
          cmd.keep    = 1'b1;
          cmd.clr_inc = 1'b1;
        end else if (stat.emit_ok) begin
          cmd.em_start = 1'b1;
        end else begin
          cmd.take    = 1'b1;
          cmd.clr_inc = 1'b1;
        end
      end
      ST_TAIL: begin
        if (stat.emit_ok) begin
          cmd.em_start = 1'b1;
        end else begin
          cmd.flush_rst = 1'b1;
        end
      end
      ST_EM_RD: cmd.em_active = 1'b1;
      ST_EM_LD: begin
        cmd.em_active = 1'b1;
        cmd.em_load   = stat.out_free;
      end
      ST_AFTER: begin
        if (tail_r) begin
          cmd.flush_rst = 1'b1;
        end else begin
          cmd.take    = 1'b1;
          cmd.clr_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_load |-> $past(state_r) == ST_EM_RD || $past(state_r) == ST_EM_LD)
    else $error("item loaded outside emission");

  a_cmp_follows_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_byte |=> cmd.cmp)
    else $error("byte capture not followed by compare");

  a_tail_flushing: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> flushing_r)
    else $error("tail emission outside flush");
`endif

endmodule
